// File: rtl/core/spcr_pkg.sv
package spcr_pkg;

  // Field and port widths
  localparam int unsigned LevelW   = 10;
  localparam int unsigned MarginW  = 13;
  localparam int unsigned BoostW   = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned PowerW   = 16;
  localparam int unsigned CntW     = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // Beat kinds carried in the slave-side tuser
  typedef enum logic [KindW-1:0] {
    KindTick  = 2'd0,
    KindOff   = 2'd1,
    KindEmerg = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxLevel  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMargin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoostPwr  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPGain     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIGain     = 3'd4;

  // Register reset values
  localparam logic [LevelW-1:0]         MaxLevelRst = 10'd1023;
  localparam logic signed [MarginW-1:0] MarginRst   = -13'sd50;
  localparam logic [BoostW-1:0]         BoostPwrRst = 12'd500;
  localparam logic [GainW-1:0]          PGainRst    = 16'd256;
  localparam logic [GainW-1:0]          IGainRst    = 16'd64;

  // Tick counts
  localparam logic [CntW-1:0] OffDelay      = 3'd4;
  localparam logic [CntW-1:0] OffDelayBoost = 3'd5;
  localparam logic [CntW-1:0] WarmupTicks   = 3'd5;

  // Division by three: floor(x * 683 / 2048), exact for x below 2048
  localparam logic [9:0] Recip3   = 10'd683;
  localparam int unsigned Recip3Sh = 11;

  // Result beat, dac_code in the lowest bits
  typedef struct packed {
    logic              regulating;
    logic              boost_on;
    logic              power_on;
    logic [LevelW-1:0] dac_code;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// File: rtl/core/surplus_power_charger_regulator.sv
// Surplus-power charger regulator.
// Slave stream (s_axis_*): one beat per command. tuser carries the kind (control
// tick, off, emergency charge); tdata carries the measured grid power and flags.
// Master stream (m_axis_*): exactly one result beat per accepted command, giving
// the DAC code, the power and booster switch drives and the regulating flag.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
// edge; write only while no command is in flight.
// Timing: an accepted command's result is registered in the output buffer.
// The state update (one 16x16 multiply, an add and the clamp) lies between
// the state registers and the result register, so the throughput is one
// beat per cycle while tready is high. A two-entry output buffer (result
// register plus skid register) lets a new command in while a result waits;
// tready drops only when both entries hold results, so a stall of the
// receiver holds the oldest result and blocks the input after one further beat.
// Reset: state clears to zero (charger idle, level 0, booster off), the
// configuration returns to its defaults and the output buffer empties.
module surplus_power_charger_regulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: grid_power_w[15:0], boost_allowed[16], battery_full[17],
  //        emergency_enable[18], heating[19], zero[23:20]
  input  logic [spcr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [spcr_pkg::KindW-1:0]    s_axis_tuser,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: dac_code[9:0], power_on[10], boost_on[11], regulating[12], zero[15:13]
  output logic [spcr_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [spcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spcr_pkg::CfgDataW-1:0] cfg_data_i
);
  import spcr_pkg::*;

  // configuration registers
  logic [LevelW-1:0]         max_q;
  logic signed [MarginW-1:0] margin_q;
  logic [BoostW-1:0]         boost_pwr_q;
  logic [GainW-1:0]          p_gain_q;
  logic [GainW-1:0]          i_gain_q;

  // regulator state
  logic [LevelW-1:0] level_q, level_d;
  logic              active_q, active_d;
  logic              power_q, power_d;
  logic              boost_q, boost_d;
  logic [CntW-1:0]   off_q, off_d;
  logic [CntW-1:0]   warm_q, warm_d;

  // output buffer
  result_t out_q, skid_q, res_d;
  logic    out_valid_q, skid_valid_q;

  // input fields
  kind_e                    kind;
  logic signed [PowerW-1:0] w;
  logic                     boost_ok, full, en, heat;
  logic                     in_fire, out_fire;

  // datapath
  logic signed [PowerW:0]   w_x, margin_x, boost_x, err;
  logic signed [MarginW-1:0] half_margin;
  logic [PowerW:0]          mag_x;
  logic [GainW-1:0]         gain;
  logic [2*GainW-1:0]       prod;
  logic [2*GainW:0]         rnd;
  logic [2*GainW-8:0]       q;
  logic signed [2*GainW-6:0] step;
  logic signed [2*GainW-5:0] sum;
  logic [LevelW-1:0]        clamped;
  logic [LevelW:0]          max_p1;
  logic [LevelW+10:0]       third_prod;
  logic [LevelW-1:0]        third;
  logic                     below_margin, in_dead, below_boost, below_neg_boost;
  logic                     w_nonpos;
  logic                     boost_tmp, hold;
  logic [CntW-1:0]          off_tmp;

  // unpack the input beat
  assign kind     = kind_e'(s_axis_tuser);
  assign w        = s_axis_tdata[PowerW-1:0];
  assign boost_ok = s_axis_tdata[PowerW];
  assign full     = s_axis_tdata[PowerW+1];
  assign en       = s_axis_tdata[PowerW+2];
  assign heat     = s_axis_tdata[PowerW+3];

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = out_valid_q && m_axis_tready;

  // compares against the margin and booster power
  assign w_x             = {w[PowerW-1], w};
  assign margin_x        = {{(PowerW+1-MarginW){margin_q[MarginW-1]}}, margin_q};
  assign boost_x         = {{(PowerW+1-BoostW){1'b0}}, boost_pwr_q};
  assign w_nonpos        = w[PowerW-1] || (w == '0);
  assign below_margin    = w_x < margin_x;
  assign in_dead         = (w_x > margin_x) && w_nonpos;
  assign below_boost     = w_x < boost_x;
  assign below_neg_boost = w_x < -boost_x;

  // error against half the margin, scaled by the selected gain and rounded
  assign half_margin = margin_q >>> 1;
  assign err   = w_x - {{(PowerW+1-MarginW){half_margin[MarginW-1]}}, half_margin};
  assign mag_x = err[PowerW] ? $unsigned(-err) : $unsigned(err);
  assign gain  = full ? p_gain_q : i_gain_q;
  assign prod  = (2*GainW)'(mag_x[GainW-1:0]) * (2*GainW)'(gain);
  assign rnd   = {1'b0, prod} + (2*GainW+1)'(128);
  assign q     = rnd[2*GainW:8];
  assign step  = err[PowerW] ? -$signed({2'b0, q}) : $signed({2'b0, q});
  assign sum   = $signed({step[2*GainW-6], step})
               + $signed({{(2*GainW-4-LevelW){1'b0}},
                          (full ? {LevelW{1'b0}} : level_q)});

  // saturate to 0..max_level
  always_comb begin
    if (sum > $signed({{(2*GainW-4-LevelW){1'b0}}, max_q})) begin
      clamped = max_q;
    end else if (sum[2*GainW-5]) begin
      clamped = '0;
    end else begin
      clamped = sum[LevelW-1:0];
    end
  end

  // round(max_level / 3) as floor((max_level + 1) / 3)
  assign max_p1     = {1'b0, max_q} + (LevelW+1)'(1);
  assign third_prod = (LevelW+11)'(max_p1) * (LevelW+11)'(Recip3);
  assign third      = third_prod[Recip3Sh +: LevelW];

  // next state for the offered beat
  always_comb begin
    level_d   = level_q;
    active_d  = active_q;
    power_d   = power_q;
    boost_d   = boost_q;
    off_d     = off_q;
    warm_d    = warm_q;
    boost_tmp = boost_q;
    hold      = 1'b0;
    off_tmp   = off_q;
    case (kind)
      KindTick: begin
        if (!active_q) begin
          if (below_margin) begin
            level_d  = '0;
            power_d  = 1'b1;
            active_d = 1'b1;
            off_d    = OffDelay;
            warm_d   = WarmupTicks;
          end
        end else if (warm_q != '0) begin
          warm_d = warm_q - CntW'(1);
        end else if (!in_dead) begin
          // booster switching
          if (!boost_ok && boost_q) begin
            boost_tmp = 1'b0;
          end else if (boost_ok && below_boost && (level_q >= max_q) && !boost_q) begin
            boost_tmp = 1'b1;
            hold      = 1'b1;
          end
          boost_d = boost_tmp;
          if (!hold) begin
            level_d = clamped;
            // drop the booster once the level falls to half
            if (boost_tmp && ({clamped, 1'b0} <= {1'b0, max_q})) begin
              boost_d = 1'b0;
              if (below_neg_boost) begin
                off_tmp = OffDelayBoost;
              end
            end
            // delayed turn-off
            if ((clamped != '0) || w_nonpos) begin
              active_d = 1'b1;
              off_d    = OffDelay;
            end else if (off_tmp != '0) begin
              off_d = off_tmp - CntW'(1);
            end else begin
              active_d = 1'b0;
              off_d    = off_tmp;
            end
            power_d = active_d;
          end
        end
      end
      KindOff: begin
        level_d  = '0;
        power_d  = 1'b0;
        active_d = 1'b0;
      end
      KindEmerg: begin
        if (!active_q) begin
          level_d = (en && heat) ? third : '0;
          power_d = en;
        end
      end
      default: begin
      end
    endcase
  end

  // result beat from the next state
  always_comb begin
    res_d.dac_code   = (level_d > max_q) ? max_q : level_d;
    res_d.power_on   = power_d;
    res_d.boost_on   = boost_d;
    res_d.regulating = active_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MaxLevelRst;
      margin_q    <= MarginRst;
      boost_pwr_q <= BoostPwrRst;
      p_gain_q    <= PGainRst;
      i_gain_q    <= IGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxLevel: max_q       <= cfg_data_i[LevelW-1:0];
        RegMargin:   margin_q    <= cfg_data_i[MarginW-1:0];
        RegBoostPwr: boost_pwr_q <= cfg_data_i[BoostW-1:0];
        RegPGain:    p_gain_q    <= cfg_data_i[GainW-1:0];
        RegIGain:    i_gain_q    <= cfg_data_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance the regulator state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      active_q <= 1'b0;
      power_q  <= 1'b0;
      boost_q  <= 1'b0;
      off_q    <= '0;
      warm_q   <= '0;
    end else if (in_fire) begin
      level_q  <= level_d;
      active_q <= active_d;
      power_q  <= power_d;
      boost_q  <= boost_d;
      off_q    <= off_d;
      warm_q   <= warm_d;
    end
  end

  // output buffer valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_fire;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire) begin
          skid_q <= res_d;
        end
      end else if (in_fire) begin
        out_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-ResultW)'(0), out_q};

endmodule

// File: rtl/core/spcr_checker.sv
module spcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spcr_pkg::OutDataW-1:0] m_axis_tdata
);
  import spcr_pkg::*;

  result_t res;
  assign res = m_axis_tdata[ResultW-1:0];

  // a beat taken into an empty buffer is offered on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("accepted beat not offered after one cycle");

  // input blocks only when a result is waiting
  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result offered");

  // an active regulator always has the charger powered
  a_reg_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.regulating |-> res.power_on)
    else $error("regulating without charger power");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind surplus_power_charger_regulator spcr_checker u_spcr_checker (.*);

// File: tb/surplus_power_charger_regulator_checker.sv
module surplus_power_charger_regulator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata: grid_power_w, boost_allowed, battery_full, emergency_enable, heating, zero
  input  logic [spcr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind
  input  logic [spcr_pkg::KindW-1:0]    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: dac_code, power_on, boost_on, regulating, zero
  input  logic [spcr_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [spcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spcr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import spcr_pkg::*;

  // Flag positions above the power field in the command beat
  localparam int unsigned BoostOkBit = PowerW;
  localparam int unsigned FullBit    = PowerW + 1;
  localparam int unsigned EnableBit  = PowerW + 2;
  localparam int unsigned HeatBit    = PowerW + 3;

  // Register copies
  logic [LevelW-1:0]         cfg_max_level;
  logic signed [MarginW-1:0] cfg_margin;
  logic [BoostW-1:0]         cfg_boost_pwr;
  logic [GainW-1:0]          cfg_p_gain;
  logic [GainW-1:0]          cfg_i_gain;

  // Regulator state as predicted
  logic [LevelW-1:0] level;
  logic              active;
  logic              powered;
  logic              boosted;
  logic [CntW-1:0]   off_left;
  logic [CntW-1:0]   warm_left;

  result_t expected_drive[$];
  int      outstanding  = 0;
  int      mismatches   = 0;
  int      results_seen = 0;

  assign pending_o    = outstanding;
  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Scale the error by a Q8.8 gain, rounding half away from zero
  function automatic longint round_gain_step(longint err, longint gain);
    longint mag;
    longint q;
    mag = (err < 0) ? -err : err;
    q   = (mag * gain + 128) >>> 8;
    return (err < 0) ? -q : q;
  endfunction

  // One control tick: start, warm-up, dead band, booster, P or I step, off delay
  function automatic void regulate_tick(int watts, logic boost_ok, logic full);
    int     margin_i;
    int     err;
    longint next_level;
    margin_i = int'(cfg_margin);
    if (!active) begin
      if (watts < margin_i) begin
        level     = '0;
        powered   = 1'b1;
        active    = 1'b1;
        off_left  = OffDelay;
        warm_left = WarmupTicks;
      end
      return;
    end
    if (warm_left != 0) begin
      warm_left = warm_left - 1'b1;
      return;
    end
    if (watts > margin_i && watts <= 0) return;

    if (!boost_ok && boosted) begin
      boosted = 1'b0;
    end else if (boost_ok && watts < int'(cfg_boost_pwr) && level >= cfg_max_level &&
                 !boosted) begin
      boosted = 1'b1;
      return;
    end

    err = watts - (margin_i >>> 1);
    if (full) next_level = round_gain_step(err, longint'(cfg_p_gain));
    else      next_level = longint'(level) + round_gain_step(err, longint'(cfg_i_gain));
    if (next_level > longint'(cfg_max_level)) next_level = longint'(cfg_max_level);
    else if (next_level < 0)                  next_level = 0;
    level = next_level[LevelW-1:0];

    // Drop the booster once the level has fallen to half range
    if (boosted && int'(level) * 2 <= int'(cfg_max_level)) begin
      boosted = 1'b0;
      if (watts < -int'(cfg_boost_pwr)) off_left = OffDelayBoost;
    end

    if (level != 0 || watts <= 0) begin
      active   = 1'b1;
      off_left = OffDelay;
    end else if (off_left != 0) begin
      off_left = off_left - 1'b1;
    end else begin
      active = 1'b0;
    end
    powered = active;
  endfunction

  // Advance the state by one command beat and form the drives it leaves
  function automatic result_t step_regulator(logic [KindW-1:0] kind,
                                             logic [InDataW-1:0] data);
    result_t drive;
    int      emerg_level;
    case (kind)
      KindTick: regulate_tick(int'($signed(data[PowerW-1:0])), data[BoostOkBit],
                              data[FullBit]);
      KindOff: begin
        level   = '0;
        powered = 1'b0;
        active  = 1'b0;
      end
      KindEmerg: begin
        if (!active) begin
          emerg_level = (data[EnableBit] && data[HeatBit]) ?
                        (int'(cfg_max_level) + 1) / 3 : 0;
          level       = emerg_level[LevelW-1:0];
          powered     = data[EnableBit];
        end
      end
      default: ;
    endcase
    drive.dac_code   = (level > cfg_max_level) ? cfg_max_level : level;
    drive.power_on   = powered;
    drive.boost_on   = boosted;
    drive.regulating = active;
    return drive;
  endfunction

  // Track register writes, predict each command, compare each result beat
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      cfg_max_level = MaxLevelRst;
      cfg_margin    = MarginRst;
      cfg_boost_pwr = BoostPwrRst;
      cfg_p_gain    = PGainRst;
      cfg_i_gain    = IGainRst;
      level         = '0;
      active        = 1'b0;
      powered       = 1'b0;
      boosted       = 1'b0;
      off_left      = '0;
      warm_left     = '0;
      expected_drive.delete();
      outstanding   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMaxLevel: cfg_max_level = cfg_data_i[LevelW-1:0];
          RegMargin:   cfg_margin    = cfg_data_i[MarginW-1:0];
          RegBoostPwr: cfg_boost_pwr = cfg_data_i[BoostW-1:0];
          RegPGain:    cfg_p_gain    = cfg_data_i[GainW-1:0];
          RegIGain:    cfg_i_gain    = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[ResultW-1:0];
        results_seen++;
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = expected_drive.pop_front();
          if (seen.dac_code !== want.dac_code)
            report_mismatch($sformatf("result %0d dac_code %0d, expected %0d",
                                      results_seen, seen.dac_code, want.dac_code));
          if (seen.power_on !== want.power_on)
            report_mismatch($sformatf("result %0d power_on %b, expected %b",
                                      results_seen, seen.power_on, want.power_on));
          if (seen.boost_on !== want.boost_on)
            report_mismatch($sformatf("result %0d boost_on %b, expected %b",
                                      results_seen, seen.boost_on, want.boost_on));
          if (seen.regulating !== want.regulating)
            report_mismatch($sformatf("result %0d regulating %b, expected %b",
                                      results_seen, seen.regulating, want.regulating));
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        expected_drive.push_back(step_regulator(s_axis_tuser, s_axis_tdata));
      outstanding = expected_drive.size();
    end
  end

endmodule

// File: tb/surplus_power_charger_regulator_tb.sv
module surplus_power_charger_regulator_tb;
  import spcr_pkg::*;

  localparam int HalfPeriod     = 10;
  localparam int ResetCycles    = 5;
  localparam int CycleLimit     = 200000;
  localparam int Phases         = 6;
  localparam int RandomPerPhase = 125;
  localparam int HeldItems      = 20;
  localparam int RxHoldCycles   = 300;
  localparam int SettleCycles   = 8;
  localparam int MaxGap         = 19;
  localparam logic [KindW-1:0] KindSpare = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [KindW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int pending_results;
  int cycle_count;
  int cur_margin;
  bit tx_brisk;
  bit rx_brisk;
  bit rx_hold_req;

  always #(HalfPeriod) clk_i = ~clk_i;

  surplus_power_charger_regulator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  surplus_power_charger_regulator_checker drive_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending_results),
    .fail_count_o  (fail_count)
  );

  function automatic logic [InDataW-1:0] pack_cmd(logic [PowerW-1:0] watts, logic boost_ok,
                                                  logic full, logic en, logic heat);
    return {{(InDataW - PowerW - 4){1'b0}}, heat, en, full, boost_ok, watts};
  endfunction

  // Offer a beat after a random gap unless tx_brisk; hold until tready reads high
  task automatic send_beat(logic [KindW-1:0] kind, logic [InDataW-1:0] data);
    int gap;
    gap = tx_brisk ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_tick(int watts, logic boost_ok, logic full);
    send_beat(KindTick, pack_cmd(watts[PowerW-1:0], boost_ok, full,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
  endtask

  // Drop valid and wait until every result has been taken
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CfgIdxW-1:0] idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
  endtask

  task automatic load_settings(int max_lv, int margin, int boost, int pg, int ig);
    settle_idle();
    put_reg(RegMaxLevel, max_lv);
    put_reg(RegMargin, margin);
    put_reg(RegBoostPwr, boost);
    put_reg(RegPGain, pg);
    put_reg(RegIGain, ig);
    cfg_we_i   <= 1'b0;
    cur_margin = margin;
  endtask

  // Grid power mostly near the target, with extremes, dead band and start values
  function automatic int pick_power();
    int watts;
    case ($urandom_range(0, 9))
      0:       watts = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2:    watts = int'($urandom_range(0, 65535)) - 32768;
      3, 4, 5, 6: watts = (cur_margin >>> 1) + int'($urandom_range(0, 400)) - 200;
      7:       watts = (cur_margin < 0) ? -int'($urandom_range(0, -cur_margin - 1)) : 0;
      8:       watts = $urandom_range(1, 100);
      default: watts = cur_margin - int'($urandom_range(1, 2000));
    endcase
    if (watts > 32767)  watts = 32767;
    if (watts < -32768) watts = -32768;
    return watts;
  endfunction

  // Mostly control ticks, with off, emergency and unused kinds mixed in
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 88)
      send_tick(pick_power(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      send_beat((pick < 93) ? KindOff : (pick < 98) ? KindEmerg : KindSpare,
                pack_cmd(PowerW'($urandom()), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
  endtask

  // Timeout
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : accept_results
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = rx_brisk ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Command side and verdict
  initial begin : run_commands
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KindTick;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegMaxLevel;
    cfg_data_i    = '0;
    tx_brisk      = 1'b0;
    rx_brisk      = 1'b0;
    rx_hold_req   = 1'b0;
    cur_margin    = int'(MarginRst);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: start, warm-up, dead band, I and P steps, booster, commands
    send_tick(0, 1'b0, 1'b0);
    send_tick(-32768, 1'b1, 1'b0);
    repeat (5) send_tick(32767, 1'b1, 1'b1);
    send_tick(-10, 1'b1, 1'b0);
    send_tick(32767, 1'b0, 1'b0);
    send_tick(100, 1'b1, 1'b0);
    send_tick(-32768, 1'b1, 1'b1);
    send_tick(1, 1'b0, 1'b0);
    send_tick(300, 1'b0, 1'b1);
    send_tick(-51, 1'b0, 1'b0);
    send_beat(KindSpare, pack_cmd('1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_beat(KindEmerg, pack_cmd('0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_beat(KindOff, pack_cmd('0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_beat(KindEmerg, pack_cmd('0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_beat(KindEmerg, pack_cmd('0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_beat(KindEmerg, pack_cmd('0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_beat(KindOff, pack_cmd('1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(-51, 1'b0, 1'b0);

    // Random phases, each under its own register settings
    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: load_settings(1023, -4096, 4095, 65535, 65535);
        1: load_settings(0, 0, 0, 0, 0);
        2: load_settings(300, -50, 500, 256, 64);
        3: load_settings(1023, 4095, 200, 3, 1);
        4: load_settings($urandom_range(0, 1023), int'($urandom_range(0, 8191)) - 4096,
                         $urandom_range(0, 4095), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
        default: load_settings($urandom_range(0, 1023), -int'($urandom_range(0, 4096)),
                               $urandom_range(0, 4095), $urandom_range(0, 1023),
                               $urandom_range(0, 1023));
      endcase
      // Hold the result side off while commands keep coming, to fill the buffer
      if (phase == 2) begin
        rx_hold_req = 1'b1;
        tx_brisk    = 1'b1;
        repeat (HeldItems) random_item();
      end
      for (int i = 0; i < RandomPerPhase; i++) begin
        if (i % 25 == 0) begin
          tx_brisk = ($urandom_range(0, 3) == 0);
          rx_brisk = ($urandom_range(0, 3) == 0);
        end
        random_item();
      end
    end

    settle_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/spcr_pkg.sv
rtl/core/surplus_power_charger_regulator.sv
rtl/core/spcr_checker.sv
tb/surplus_power_charger_regulator_checker.sv
tb/surplus_power_charger_regulator_tb.sv
